// ===== design/segment_intersection_test_top_assert.svh =====
// assertion macros for the segment intersection test block
`ifndef SEGMENT_INTERSECTION_TEST_TOP_ASSERT_SVH
`define SEGMENT_INTERSECTION_TEST_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define SIT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sit assertion failed");
// next-cycle implication, checked outside reset
`define SIT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sit assertion failed");
`else
`define SIT_ASSERT_NOW(lbl, ante, cons)
`define SIT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/sit_pkg.sv =====
// shared constants and types for the segment intersection test block
package sit_pkg;

    // default coordinate width
    localparam int COORD_BITS_DEF = 16;

    // per-stage load enables from the pipeline control
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } sit_adv_t;

endpackage

// ===== design/sit_datapath.sv =====
// four-stage arithmetic datapath of the segment intersection test
module sit_datapath #(
    parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
    input  logic                           clk,
    input  sit_pkg::sit_adv_t              adv,
    input  logic signed [COORD_BITS-1:0]   a_start_x,
    input  logic signed [COORD_BITS-1:0]   a_start_y,
    input  logic signed [COORD_BITS-1:0]   a_end_x,
    input  logic signed [COORD_BITS-1:0]   a_end_y,
    input  logic signed [COORD_BITS-1:0]   b_start_x,
    input  logic signed [COORD_BITS-1:0]   b_start_y,
    input  logic signed [COORD_BITS-1:0]   b_end_x,
    input  logic signed [COORD_BITS-1:0]   b_end_y,
    output logic                           intersects
);
    import sit_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int DW = W + 1;       // coordinate difference
    localparam int PW = 2 * W + 2;   // product of two differences
    localparam int SW = 2 * W + 3;   // sum or difference of two products

    // stage 1: point detection, role swap, differences
    logic                 a_pt, b_pt, swap;
    logic signed [W-1:0]  px, py, ex, ey, qx, qy, fx, fy;
    logic signed [DW-1:0] rx_next, ry_next, sx_next, sy_next;
    logic signed [DW-1:0] dx_next, dy_next, gx_next, gy_next;
    logic                 both_next, eq_next;

    always_comb
    begin
        a_pt = (a_start_x == a_end_x) && (a_start_y == a_end_y);
        b_pt = (b_start_x == b_end_x) && (b_start_y == b_end_y);
        // a point-like first segment is tested against the second instead
        swap = a_pt;
        px = swap ? b_start_x : a_start_x;
        py = swap ? b_start_y : a_start_y;
        ex = swap ? b_end_x   : a_end_x;
        ey = swap ? b_end_y   : a_end_y;
        qx = swap ? a_start_x : b_start_x;
        qy = swap ? a_start_y : b_start_y;
        fx = swap ? a_end_x   : b_end_x;
        fy = swap ? a_end_y   : b_end_y;
        rx_next = DW'(ex) - DW'(px);
        ry_next = DW'(ey) - DW'(py);
        sx_next = DW'(fx) - DW'(qx);
        sy_next = DW'(fy) - DW'(qy);
        dx_next = DW'(qx) - DW'(px);
        dy_next = DW'(qy) - DW'(py);
        gx_next = DW'(fx) - DW'(px);
        gy_next = DW'(fy) - DW'(py);
        both_next = a_pt && b_pt;
        eq_next   = (a_start_x == b_start_x) && (a_start_y == b_start_y);
    end

    logic signed [DW-1:0] rx_reg, ry_reg, sx_reg, sy_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, gx_reg, gy_reg;
    logic                 both1_reg, eq1_reg;

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            rx_reg    <= rx_next;
            ry_reg    <= ry_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            gx_reg    <= gx_next;
            gy_reg    <= gy_next;
            both1_reg <= both_next;
            eq1_reg   <= eq_next;
        end
    end

    // stage 2: all partial products
    logic signed [PW-1:0] rxsy_reg, rysx_reg, dxsy_reg, dysx_reg, dxry_reg, dyrx_reg;
    logic signed [PW-1:0] rxrx_reg, ryry_reg, dxrx_reg, dyry_reg, gxrx_reg, gyry_reg;
    logic                 both2_reg, eq2_reg;

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            rxsy_reg  <= PW'(rx_reg) * PW'(sy_reg);
            rysx_reg  <= PW'(ry_reg) * PW'(sx_reg);
            dxsy_reg  <= PW'(dx_reg) * PW'(sy_reg);
            dysx_reg  <= PW'(dy_reg) * PW'(sx_reg);
            dxry_reg  <= PW'(dx_reg) * PW'(ry_reg);
            dyrx_reg  <= PW'(dy_reg) * PW'(rx_reg);
            rxrx_reg  <= PW'(rx_reg) * PW'(rx_reg);
            ryry_reg  <= PW'(ry_reg) * PW'(ry_reg);
            dxrx_reg  <= PW'(dx_reg) * PW'(rx_reg);
            dyry_reg  <= PW'(dy_reg) * PW'(ry_reg);
            gxrx_reg  <= PW'(gx_reg) * PW'(rx_reg);
            gyry_reg  <= PW'(gy_reg) * PW'(ry_reg);
            both2_reg <= both1_reg;
            eq2_reg   <= eq1_reg;
        end
    end

    // stage 3: cross products and projections
    logic signed [SW-1:0] d_reg, t_reg, u_reg, rr_reg, t0_reg, t1_reg;
    logic                 both3_reg, eq3_reg;

    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            d_reg     <= SW'(rxsy_reg) - SW'(rysx_reg);
            t_reg     <= SW'(dxsy_reg) - SW'(dysx_reg);
            u_reg     <= SW'(dxry_reg) - SW'(dyrx_reg);
            rr_reg    <= SW'(rxrx_reg) + SW'(ryry_reg);
            t0_reg    <= SW'(dxrx_reg) + SW'(dyry_reg);
            t1_reg    <= SW'(gxrx_reg) + SW'(gyry_reg);
            both3_reg <= both2_reg;
            eq3_reg   <= eq2_reg;
        end
    end

    // stage 4: range checks and final decision
    logic d_pos, d_zero, cross_hit, coll_hit, hit_next;

    always_comb
    begin
        d_pos  = (d_reg > 0);
        d_zero = (d_reg == 0);
        // negative cross product: bounds flip instead of negating
        if (d_pos)
        begin
            cross_hit = (t_reg >= 0) && (t_reg <= d_reg) && (u_reg >= 0) && (u_reg <= d_reg);
        end
        else
        begin
            cross_hit = (t_reg <= 0) && (t_reg >= d_reg) && (u_reg <= 0) && (u_reg >= d_reg);
        end
        // parallel: collinear and projections not both beyond the same end
        coll_hit = (u_reg == 0)
                   && !((t0_reg < 0) && (t1_reg < 0))
                   && !((t0_reg > rr_reg) && (t1_reg > rr_reg));
        if (both3_reg)
        begin
            hit_next = eq3_reg;
        end
        else
        begin
            hit_next = d_zero ? coll_hit : cross_hit;
        end
    end

    logic intersects_reg;

    always_ff @(posedge clk)
    begin
        if (adv.s4)
        begin
            intersects_reg <= hit_next;
        end
    end

    assign intersects = intersects_reg;

endmodule

// ===== design/segment_intersection_test_top.sv =====
// segment intersection test top level, one segment pair per transfer
// path: an accepted pair passes the difference, product, sum and compare stage registers in
// order; out_valid rises when it reaches the compare stage and it transfers while out_stall is low
// throughput: one pair per cycle; each stage holds its item under stall
// reset: asynchronous active-low rst_n clears all stage valid bits, data is not reset
module segment_intersection_test_top #(
    parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [COORD_BITS-1:0]   a_start_x,
    input  logic signed [COORD_BITS-1:0]   a_start_y,
    input  logic signed [COORD_BITS-1:0]   a_end_x,
    input  logic signed [COORD_BITS-1:0]   a_end_y,
    input  logic signed [COORD_BITS-1:0]   b_start_x,
    input  logic signed [COORD_BITS-1:0]   b_start_y,
    input  logic signed [COORD_BITS-1:0]   b_end_x,
    input  logic signed [COORD_BITS-1:0]   b_end_y,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           intersects
);
    import sit_pkg::*;

    // stage valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic rdy1, rdy2, rdy3, rdy4;
    sit_adv_t adv;

    // a stage loads when it is empty or its item moves on
    always_comb
    begin
        rdy4 = !v4_reg || !out_stall;
        rdy3 = !v3_reg || rdy4;
        rdy2 = !v2_reg || rdy3;
        rdy1 = !v1_reg || rdy2;
        adv.s1 = rdy1;
        adv.s2 = rdy2;
        adv.s3 = rdy3;
        adv.s4 = rdy4;
        v1_next = rdy1 ? in_valid : v1_reg;
        v2_next = rdy2 ? v1_reg : v2_reg;
        v3_next = rdy3 ? v2_reg : v3_reg;
        v4_next = rdy4 ? v3_reg : v4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    assign in_stall  = !rdy1;
    assign out_valid = v4_reg;

    // arithmetic pipeline
    sit_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk        (clk),
        .adv        (adv),
        .a_start_x  (a_start_x),
        .a_start_y  (a_start_y),
        .a_end_x    (a_end_x),
        .a_end_y    (a_end_y),
        .b_start_x  (b_start_x),
        .b_start_y  (b_start_y),
        .b_end_x    (b_end_x),
        .b_end_y    (b_end_y),
        .intersects (intersects)
    );

    // pipeline control checks
`include "segment_intersection_test_top_assert.svh"

    `SIT_ASSERT_NOW(a_full_stalls, out_valid && out_stall && v1_reg && v2_reg && v3_reg, in_stall)
    `SIT_ASSERT_NEXT(a_accept_lands, in_valid && !in_stall, v1_reg)
    `SIT_ASSERT_NEXT(a_stage3_drains, v3_reg && !out_stall, out_valid)

endmodule
